// File: src/hcbd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
// No dependencies; used by hcbd_step and http_chunked_body_decoder.
package hcbd_pkg;

   localparam int          LINE_BYTES_DEFAULT = 32;
   localparam logic [31:0] CAPACITY_RESET     = 32'hFFFF_FFFF;

   localparam logic [7:0]  CHAR_SEMI = 8'h3B;
   localparam logic [7:0]  CHAR_CR   = 8'h0D;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [31:0] CRLF_LEN  = 32'd2;

   typedef enum logic [3:0] {
      PH_SIZE = 4'b0001,
      PH_DATA = 4'b0010,
      PH_CRLF = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   typedef enum logic {
      OP_FEED    = 1'b0,
      OP_RESTART = 1'b1
   } opcode_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] size_acc;
      logic        past_ext;
      logic        bad_digit;
      logic [31:0] bytes_rem;
      logic        final_seen;
      logic        finished;
      logic [31:0] stored_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_SIZE,
      size_acc:     32'd0,
      past_ext:     1'b0,
      bad_digit:    1'b0,
      bytes_rem:    32'd0,
      final_seen:   1'b0,
      finished:     1'b0,
      stored_count: 32'd0
   };

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] byte_value;
      logic       last_in_buffer;
   } req_item_type;

   typedef struct packed {
      logic       body_valid;
      logic [7:0] body_byte;
      logic       framing_error;
      logic       body_done;
      logic       buffer_end;
   } rsp_item_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h41 + 8'd10);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: src/hcbd_step.sv
// Single-pass next-state and result logic for one request of the decoder.
// Depends on hcbd_pkg.
module hcbd_step #(
   parameter int LINE_BYTES = hcbd_pkg::LINE_BYTES_DEFAULT,
   localparam int CNT_W     = $clog2(LINE_BYTES)
) (
   input  hcbd_pkg::state_type    cur_state,
   input  logic [CNT_W-1:0]       cur_count,
   input  logic [31:0]            capacity,
   input  hcbd_pkg::req_item_type item,
   output hcbd_pkg::state_type    nxt_state,
   output logic [CNT_W-1:0]       nxt_count,
   output hcbd_pkg::rsp_item_type result
);

   hcbd_pkg::hex_type hex;
   logic [31:0]       rem_dec;

   assign hex     = hcbd_pkg::hex_digit(item.byte_value);
   assign rem_dec = (cur_state.bytes_rem != 32'd0) ? cur_state.bytes_rem - 32'd1 : 32'd0;

   always_comb begin
      nxt_state            = cur_state;
      nxt_count            = cur_count;
      result               = '0;
      result.buffer_end    = item.last_in_buffer;
      if (item.opcode == hcbd_pkg::OP_RESTART) begin
         nxt_state = hcbd_pkg::STATE_RESET;
         nxt_count = '0;
      end else begin
         unique case (cur_state.phase)
            hcbd_pkg::PH_SIZE: begin
               if (item.byte_value == hcbd_pkg::CHAR_LF) begin
                  if (cur_state.bad_digit) begin
                     result.framing_error = 1'b1;
                  end else begin
                     nxt_state.size_acc   = 32'd0;
                     nxt_state.past_ext   = 1'b0;
                     nxt_count            = '0;
                     nxt_state.final_seen = (cur_state.size_acc == 32'd0);
                     if (cur_state.size_acc == 32'd0) begin
                        nxt_state.bytes_rem = hcbd_pkg::CRLF_LEN;
                        nxt_state.phase     = hcbd_pkg::PH_CRLF;
                     end else begin
                        nxt_state.bytes_rem = cur_state.size_acc;
                        nxt_state.phase     = hcbd_pkg::PH_DATA;
                     end
                  end
               end else if (item.byte_value == hcbd_pkg::CHAR_CR) begin
                  // CR on the size line is skipped
               end else if (cur_count >= CNT_W'(LINE_BYTES - 1)) begin
                  result.framing_error = 1'b1;
               end else begin
                  nxt_count = cur_count + CNT_W'(1);
                  if (!cur_state.past_ext) begin
                     if (item.byte_value == hcbd_pkg::CHAR_SEMI) begin
                        nxt_state.past_ext = 1'b1;
                     end else if (!hex.ok) begin
                        nxt_state.bad_digit = 1'b1;
                     end else begin
                        nxt_state.size_acc = {cur_state.size_acc[27:0], hex.value};
                     end
                  end
               end
            end
            hcbd_pkg::PH_DATA: begin
               if (cur_state.stored_count < capacity) begin
                  nxt_state.stored_count = cur_state.stored_count + 32'd1;
                  result.body_valid      = 1'b1;
                  result.body_byte       = item.byte_value;
               end
               if (rem_dec == 32'd0) begin
                  nxt_state.bytes_rem = hcbd_pkg::CRLF_LEN;
                  nxt_state.phase     = hcbd_pkg::PH_CRLF;
               end else begin
                  nxt_state.bytes_rem = rem_dec;
               end
            end
            hcbd_pkg::PH_CRLF: begin
               if (item.byte_value != hcbd_pkg::CHAR_CR &&
                   item.byte_value != hcbd_pkg::CHAR_LF) begin
                  result.framing_error = 1'b1;
               end else begin
                  nxt_state.bytes_rem = rem_dec;
                  if (rem_dec == 32'd0) begin
                     if (cur_state.final_seen) begin
                        nxt_state.finished = 1'b1;
                        nxt_state.phase    = hcbd_pkg::PH_DONE;
                     end else begin
                        nxt_state.phase    = hcbd_pkg::PH_SIZE;
                     end
                  end
               end
            end
            hcbd_pkg::PH_DONE: begin
               // body complete, bytes ignored
            end
            default: begin
               nxt_state = cur_state;
            end
         endcase
      end
      result.body_done = nxt_state.finished;
   end

endmodule

// File: src/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder: stream ports, input and result registers.
// Depends on hcbd_pkg and hcbd_step.
//
// Decodes an HTTP/1.1 chunked body one byte per request and returns exactly one result per
// request, in order. A request is either a byte to feed or a restart (tuser = 1) that clears
// all decoder state but keeps the capacity register. The block takes a new request every
// clock cycle as long as results are taken; each request is held in the input register and
// is then processed in a single combinational pass into the result register, which drives
// rsp_tvalid. The decoder state advances only as a request moves into the result register,
// so a stalled rsp_tready simply holds both registers. Capacity (csr_wr_data) limits how
// many body bytes are flagged valid per body; later data bytes are still consumed. Write it
// only while the block is idle. A size line byte that would become stored character
// LINE_BYTES-1 or later and bad CR/LF are flagged as framing errors and leave the state
// untouched; a bad hex digit is recorded and flagged as a framing error at the line's LF.
module http_chunked_body_decoder #(
   parameter int LINE_BYTES = hcbd_pkg::LINE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [0:0]  req_tuser,   // [0] opcode
   input  logic        req_tlast,   // last_in_buffer
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] body_byte
   output logic [2:0]  rsp_tuser,   // [0] body_valid, [1] framing_error, [2] body_done
   output logic        rsp_tlast,   // buffer_end
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data  // body_capacity
);

   localparam int CNT_W = $clog2(LINE_BYTES);

   // input register
   logic                   in_valid_ff, in_valid_in;
   hcbd_pkg::req_item_type in_item_ff, in_item_in;
   // result register
   logic                   out_valid_ff, out_valid_in;
   hcbd_pkg::rsp_item_type out_item_ff, out_item_in;
   // decoder state
   hcbd_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [31:0]            capacity_ff, capacity_in;

   hcbd_pkg::state_type    step_state;
   logic [CNT_W-1:0]       step_count;
   hcbd_pkg::rsp_item_type step_result;

   logic advance;   // input register moves into the result register
   logic req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   hcbd_step #(
      .LINE_BYTES (LINE_BYTES)
   ) u_step (
      .cur_state (state_ff),
      .cur_count (count_ff),
      .capacity  (capacity_ff),
      .item      (in_item_ff),
      .nxt_state (step_state),
      .nxt_count (step_count),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      capacity_in  = capacity_ff;

      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = step_result;
         state_in     = step_state;
         count_in     = step_count;
         in_valid_in  = 1'b0;
      end
      if (req_take) begin
         in_valid_in               = 1'b1;
         in_item_in.opcode         = hcbd_pkg::opcode_type'(req_tuser[0]);
         in_item_in.byte_value     = req_tdata;
         in_item_in.last_in_buffer = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hcbd_pkg::STATE_RESET;
         count_ff     <= '0;
         capacity_ff  <= hcbd_pkg::CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_item_ff.body_byte;
   assign rsp_tuser  = {out_item_ff.body_done, out_item_ff.framing_error, out_item_ff.body_valid};
   assign rsp_tlast  = out_item_ff.buffer_end;

endmodule
